// ===== sv/dsc_pkg.sv =====
package dsc_pkg;

    localparam int MAX_TARGET = 64;
    localparam int IDX_W      = $clog2(MAX_TARGET);
    localparam int LEN_W      = $clog2(MAX_TARGET + 1);
    localparam int CHAR_W     = 8;
    localparam int COUNT_W    = 32;

    localparam logic REQ_TARGET = 1'b0;
    localparam logic REQ_SOURCE = 1'b1;

    typedef logic [CHAR_W-1:0]  char_t;
    typedef logic [IDX_W-1:0]   idx_t;
    typedef logic [LEN_W-1:0]   len_t;
    typedef logic [COUNT_W-1:0] count_t;

    typedef struct packed {
        logic write_char;
        logic update;
        logic finish;
    } dsc_cmd_t;

endpackage

// ===== sv/dsc_in_if.sv =====
interface dsc_in_if
    import dsc_pkg::*;
;
    logic  valid;
    logic  ready;
    logic  req_type;
    char_t char_value;
    idx_t  target_index;
    logic  last_char;

    modport source (output valid, output req_type, output char_value,
                    output target_index, output last_char, input ready);
    modport sink   (input valid, input req_type, input char_value,
                    input target_index, input last_char, output ready);
endinterface

// ===== sv/dsc_out_if.sv =====
interface dsc_out_if
    import dsc_pkg::*;
;
    logic   valid;
    logic   ready;
    count_t subseq_count;
    logic   saturated;

    modport source (output valid, output subseq_count, output saturated, input ready);
    modport sink   (input valid, input subseq_count, input saturated, output ready);
endinterface

// ===== sv/dsc_ctrl.sv =====
module dsc_ctrl
    import dsc_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     in_valid,
    input  logic     in_req_type,
    input  logic     in_last,
    output logic     in_ready,
    output logic     out_valid,
    input  logic     out_ready,
    output dsc_cmd_t cmd
);

    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_FINISH = 2'd1;
    localparam logic [1:0] ST_HOLD   = 2'd2;

    logic [1:0] state_reg;
    logic [1:0] state_next;
    logic       accept;

    assign accept = in_valid && in_ready;

    always_comb
    begin
        state_next     = state_reg;
        in_ready       = 1'b0;
        out_valid      = 1'b0;
        cmd.write_char = 1'b0;
        cmd.update     = 1'b0;
        cmd.finish     = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready       = 1'b1;
                cmd.write_char = accept && (in_req_type == REQ_TARGET);
                cmd.update     = accept && (in_req_type == REQ_SOURCE);
                if (accept && (in_req_type == REQ_SOURCE) && in_last)
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH:
            begin
                cmd.finish = 1'b1;
                state_next = ST_HOLD;
            end
            ST_HOLD:
            begin
                out_valid      = 1'b1;
                in_ready       = out_ready || !((in_req_type == REQ_SOURCE) && in_last);
                cmd.write_char = accept && (in_req_type == REQ_TARGET);
                cmd.update     = accept && (in_req_type == REQ_SOURCE);
                if (accept && (in_req_type == REQ_SOURCE) && in_last)
                begin
                    state_next = ST_FINISH;
                end
                else if (out_ready)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

// ===== sv/dsc_datapath.sv =====
module dsc_datapath
    import dsc_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  dsc_cmd_t cmd,
    input  char_t    char_value,
    input  idx_t     target_index,
    input  logic     cfg_we,
    input  len_t     cfg_wdata,
    output count_t   subseq_count,
    output logic     saturated
);

    char_t  target_reg [MAX_TARGET];
    count_t count_reg  [MAX_TARGET];
    count_t count_next [MAX_TARGET];
    logic   ovf_cell   [MAX_TARGET];
    logic   overflow_reg;
    logic   overflow_next;
    len_t   len_reg;
    len_t   eff_len;
    idx_t   sel_idx;
    count_t result_reg;
    logic   sat_reg;

    assign eff_len = (len_reg > len_t'(MAX_TARGET)) ? len_t'(MAX_TARGET) : len_reg;
    assign sel_idx = idx_t'(eff_len - len_t'(1));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            len_reg <= len_t'(1);
        end
        else if (cfg_we)
        begin
            len_reg <= cfg_wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.write_char)
        begin
            target_reg[target_index] <= char_value;
        end
    end

    for (genvar p = 0; p < MAX_TARGET; p++)
    begin : g_cell
        logic [COUNT_W:0] sum;
        count_t           addend;
        logic             hit;

        if (p == 0)
        begin : g_first
            assign addend = count_t'(1);
        end
        else
        begin : g_rest
            assign addend = count_reg[p-1];
        end

        assign hit = (target_reg[p] == char_value) && (len_t'(p) < eff_len);
        assign sum = {1'b0, count_reg[p]} + {1'b0, addend};

        always_comb
        begin
            count_next[p] = count_reg[p];
            ovf_cell[p]   = 1'b0;
            if (hit)
            begin
                ovf_cell[p]   = sum[COUNT_W];
                count_next[p] = sum[COUNT_W] ? '1 : sum[COUNT_W-1:0];
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                count_reg[p] <= '0;
            end
            else if (cmd.finish)
            begin
                count_reg[p] <= '0;
            end
            else if (cmd.update)
            begin
                count_reg[p] <= count_next[p];
            end
        end
    end

    always_comb
    begin
        overflow_next = 1'b0;
        for (int p = 0; p < MAX_TARGET; p++)
        begin
            overflow_next = overflow_next | ovf_cell[p];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            overflow_reg <= 1'b0;
        end
        else if (cmd.finish)
        begin
            overflow_reg <= 1'b0;
        end
        else if (cmd.update)
        begin
            overflow_reg <= overflow_reg | overflow_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.finish)
        begin
            result_reg <= (eff_len == '0) ? count_t'(1) : count_reg[sel_idx];
            sat_reg    <= overflow_reg;
        end
    end

    assign subseq_count = result_reg;
    assign saturated    = sat_reg;

endmodule

// ===== sv/distinct_subsequence_counter.sv =====
// Channel | Dir | Payload                                          | Beat
// req     | in  | req_type, char_value, target_index, last_char   | valid & ready
// rsp     | out | subseq_count, saturated                          | valid & ready
// cfg     | in  | cfg_wdata (target_len)                           | cfg_we
//
// A target write or a non-final source character updates the registers when it is accepted.
// A final source character is handled in order: update, capture the count and
// clear, then the result beat, which holds until rsp.ready.
// While the result waits, target writes and non-final characters still flow;
// the next final character stalls until rsp.ready.
// Every position cell updates in the same cycle from the previous counts.
// Reset clears counts, the overflow flag and sets target_len to 1.
module distinct_subsequence_counter
    import dsc_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    dsc_in_if.sink      req,
    dsc_out_if.source   rsp,
    input  logic        cfg_we,
    input  len_t        cfg_wdata
);

    dsc_cmd_t cmd;

    dsc_ctrl u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (req.valid),
        .in_req_type (req.req_type),
        .in_last     (req.last_char),
        .in_ready    (req.ready),
        .out_valid   (rsp.valid),
        .out_ready   (rsp.ready),
        .cmd         (cmd)
    );

    dsc_datapath u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .char_value   (req.char_value),
        .target_index (req.target_index),
        .cfg_we       (cfg_we),
        .cfg_wdata    (cfg_wdata),
        .subseq_count (rsp.subseq_count),
        .saturated    (rsp.saturated)
    );

endmodule
